/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a must bring condition b in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// Condition a must bring condition b in the following cycle.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

/* rtl/core/erk_pkg.sv */
`default_nettype none
package erk_pkg;

  localparam int MAX_K       = 8;
  localparam int RANK_DEPTH  = MAX_K + 1;
  localparam int ID_W        = 8;
  localparam int SCORE_W     = 33;
  localparam int PROB_W      = 24;
  localparam int CNT_W       = 9;
  localparam int K_W         = 4;
  localparam int SCALE_W     = 24;
  localparam int SUM_W       = 27;
  localparam int NUM_W       = 48;
  localparam int WEIGHT_W    = 32;
  localparam int SLOT_W      = 3;
  localparam int IDX_W       = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int EXP_BITS    = 20;
  localparam int LOG_FRAC    = 20;

  localparam logic [CNT_W-1:0]   MAX_EXPERTS   = 9'd256;
  localparam logic [K_W-1:0]     MAX_K_CODE    = 4'd8;
  localparam logic [SUM_W-1:0]   SUM_FLOOR     = 27'd4;
  localparam logic [31:0]        LN2_Q32       = 32'd2977044472;
  localparam logic [31:0]        EXP_STEP_Q32  = 32'd4294901760;
  localparam logic [31:0]        SOFTPLUS_CUT  = 32'h0010_0000;
  localparam logic [47:0]        SQRT_START    = 48'h4000_0000_0000;
  localparam logic [SCALE_W-1:0] SCALE_RESET   = 24'd65536;
  localparam logic [31:0]        MARGIN_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0]        MARGIN_MIN    = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_K_SELECT     = 1'b0,
    REG_WEIGHT_SCALE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                      valid;
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
    logic [PROB_W-1:0]         prob;
  } rank_entry_t;

  typedef struct packed {
    logic clr;
    logic ins;
    logic rot;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/core/erk_cell.sv */
`default_nettype none
module erk_cell (
  input  wire                  clk,
  input  wire                  rst,
  input  erk_pkg::cell_ctrl_t  ctrl,
  input  erk_pkg::rank_entry_t new_entry,
  input  erk_pkg::rank_entry_t up_in,
  input  erk_pkg::rank_entry_t down_in,
  input  wire                  take_in,
  output logic                 take_out,
  output erk_pkg::rank_entry_t q
);
  import erk_pkg::*;

  // The list is sorted, so the first cell that takes the new entry is the
  // insertion point and every cell after it shifts down by one.
  assign take_out = !q.valid || (new_entry.score > q.score);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (ctrl.clr) begin
      q.valid <= 1'b0;
    end else if (ctrl.ins) begin
      if (take_in) begin
        q <= up_in;
      end else if (take_out) begin
        q <= new_entry;
      end
    end else if (ctrl.rot) begin
      q <= down_in;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/erk_prob.sv */
`default_nettype none
module erk_prob (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire signed [31:0] logit,
  output logic              done,
  output logic [erk_pkg::PROB_W-1:0] prob
);
  import erk_pkg::*;

  typedef enum logic [2:0] {P_IDLE, P_EXP, P_LOGI, P_LOG, P_LN, P_SQ, P_DONE} pstate_t;

  pstate_t            state;
  logic signed [31:0] x;
  logic [31:0]        a;
  logic [32:0]        r;
  logic [31:0]        base;
  logic [31:0]        m;
  logic [LOG_FRAC:0]  y;
  logic [4:0]         i;
  logic [47:0]        n;
  logic [47:0]        res;
  logic [47:0]        bitv;

  logic [31:0] a_in;
  logic [64:0] r_prod;
  logic [63:0] b_prod;
  logic [63:0] m_prod;
  logic [52:0] ln_prod;
  logic [32:0] r_rnd;
  logic [31:0] b_rnd;
  logic [32:0] m_sq;
  logic [33:0] m_sum;
  logic [32:0] m_half;
  logic [31:0] term;
  logic [31:0] xpos;
  logic [31:0] sp;
  logic [48:0] trial;

  assign a_in    = logit[31] ? 32'(-logit) : logit;
  assign r_prod  = r * base;
  assign b_prod  = base * base;
  assign m_prod  = m * m;
  assign ln_prod = y * LN2_Q32;
  assign r_rnd   = 33'((r_prod + 65'(64'h8000_0000)) >> 32);
  assign b_rnd   = 32'((b_prod + 64'h8000_0000) >> 32);
  assign m_sq    = 33'((m_prod + 64'h4000_0000) >> 31);
  assign m_sum   = 34'(34'h1_0000_0000 + {1'b0, r} + 34'd1);
  assign m_half  = m_sum[33:1];
  assign term    = 32'((ln_prod + 53'(64'h8_0000_0000)) >> 36);
  assign xpos    = x[31] ? 32'd0 : x;
  assign sp      = xpos + term;
  assign trial   = {1'b0, res} + {1'b0, bitv};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        P_IDLE: begin
          if (start) begin
            x    <= logit;
            a    <= a_in;
            r    <= 33'h1_0000_0000;
            base <= EXP_STEP_Q32;
            i    <= '0;
            y    <= '0;
            // Large magnitudes leave no correction term.
            state <= (a_in >= SOFTPLUS_CUT) ? P_LN : P_EXP;
          end
        end
        P_EXP: begin
          if (a[i]) begin
            r <= r_rnd;
          end
          base <= b_rnd;
          i    <= i + 5'd1;
          if (i == 5'(EXP_BITS - 1)) begin
            state <= P_LOGI;
          end
        end
        P_LOGI: begin
          if (m_half[32]) begin
            y <= (LOG_FRAC+1)'(1) << LOG_FRAC;
            m <= m_half[32:1];
          end else begin
            y <= '0;
            m <= m_half[31:0];
          end
          i     <= 5'(LOG_FRAC - 1);
          state <= P_LOG;
        end
        P_LOG: begin
          if (m_sq[32]) begin
            m    <= m_sq[32:1];
            y[i] <= 1'b1;
          end else begin
            m <= m_sq[31:0];
          end
          i <= i - 5'd1;
          if (i == 5'd0) begin
            state <= P_LN;
          end
        end
        P_LN: begin
          n     <= {sp, 16'd0};
          res   <= '0;
          bitv  <= SQRT_START;
          state <= P_SQ;
        end
        P_SQ: begin
          if ({1'b0, n} >= trial) begin
            n   <= 48'({1'b0, n} - trial);
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            state <= P_DONE;
          end
        end
        P_DONE: begin
          prob  <= res[PROB_W-1:0];
          done  <= 1'b1;
          state <= P_IDLE;
        end
        default: state <= P_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/erk_div.sv */
`default_nettype none
module erk_div (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire [erk_pkg::NUM_W-1:0]     num,
  input  wire [erk_pkg::SUM_W-1:0]     den,
  output logic                         done,
  output logic [erk_pkg::WEIGHT_W-1:0] quo
);
  import erk_pkg::*;

  logic             busy;
  logic [5:0]       cnt;
  logic [NUM_W-1:0] numr;
  logic [NUM_W-1:0] quo_r;
  logic [SUM_W:0]   rem;
  logic [SUM_W:0]   rem_sh;
  logic             ge;

  // One quotient bit per cycle, restoring.
  assign rem_sh = {rem[SUM_W-1:0], numr[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den};
  assign quo    = (|quo_r[NUM_W-1:WEIGHT_W]) ? '1 : quo_r[WEIGHT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        numr  <= num;
        quo_r <= '0;
      end else if (busy) begin
        rem   <= ge ? (rem_sh - {1'b0, den}) : rem_sh;
        quo_r <= {quo_r[NUM_W-2:0], ge};
        numr  <= numr << 1;
        cnt   <= cnt + 6'd1;
        if (cnt == 6'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/expert_router_top_k.sv */
// Top-k expert router for mixture-of-experts layers, Q16.16 fixed point.
// Input channel (in_valid/in_ready): one item per expert of a token, in expert
// order, carrying the logit, the selection bias and a flag on the final expert.
// Output channel (out_valid/out_ready): at the end of a token one item per
// selected slot, best first, with the expert, its normalised routing weight,
// the runner-up expert and the score margin; a single error item instead when
// the token is too short, too long or k_select is out of range.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 writes
// k_select, index 1 writes weight_scale; write only while the block is idle.
// Each expert passes through the iterative softplus and square root unit and is
// inserted before the next one is accepted; the sorted list itself is a row of
// nine cells that inserts in parallel. At the end of a token the list is swept
// once, then each result is computed by the bit-serial divider.
// A stalled receiver holds the current result in the output register; the
// next expert is accepted while the final result of a token still waits.
// Reset empties the list, clears the expert count, sets k_select to 1 and
// weight_scale to 1.0.
`default_nettype none
`include "assert_macros.svh"
module expert_router_top_k (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire signed [31:0]                  logit,
  input  wire signed [31:0]                  bias,
  input  wire                                last_expert,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [erk_pkg::SLOT_W-1:0]         slot_index,
  output logic [erk_pkg::ID_W-1:0]           expert_id,
  output logic [erk_pkg::WEIGHT_W-1:0]       route_weight,
  output logic [erk_pkg::ID_W-1:0]           runner_up_id,
  output logic                               runner_up_valid,
  output logic signed [31:0]                 score_margin,
  output logic                               error_flag,
  output logic                               last_result,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [erk_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [erk_pkg::SCALE_W-1:0]         cfg_data
);
  import erk_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PROB, S_CHECK, S_ERR, S_SCAN, S_PREP, S_MUL, S_DIVS, S_DIV, S_EMIT
  } state_t;

  state_t               state;
  logic [K_W-1:0]       k_sel;
  logic [SCALE_W-1:0]   scale;
  logic [CNT_W-1:0]     count;
  logic signed [31:0]   bias_q;
  logic                 last_q;
  logic [IDX_W-1:0]     j;
  logic [SLOT_W-1:0]    s;
  logic [SUM_W-1:0]     sum;
  logic signed [SCORE_W-1:0] sc_last;
  logic signed [SCORE_W-1:0] ru_score;
  logic [ID_W-1:0]      ru_id;
  logic                 ru_valid;
  logic [31:0]          margin;
  logic [NUM_W-1:0]     prod;

  logic                 prob_done;
  logic [PROB_W-1:0]    prob;
  logic                 div_done;
  logic [WEIGHT_W-1:0]  quo;

  rank_entry_t          cells [RANK_DEPTH];
  logic                 take  [RANK_DEPTH];
  rank_entry_t          new_e;
  rank_entry_t          head;
  cell_ctrl_t           ctrl;

  logic                 out_free;
  logic                 out_load;
  logic                 tok_err;
  logic                 emit_last;
  logic signed [SCORE_W:0] diff;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = ((state == S_ERR) || (state == S_EMIT)) && out_free;
  assign head      = cells[0];

  assign new_e.valid = 1'b1;
  assign new_e.id    = count[ID_W-1:0];
  assign new_e.score = $signed({{(SCORE_W-PROB_W){1'b0}}, prob})
                     + $signed({bias_q[31], bias_q});
  assign new_e.prob  = prob;

  assign tok_err = (k_sel == '0) || (k_sel > MAX_K_CODE)
                || (count < {{(CNT_W-K_W){1'b0}}, k_sel}) || (count > MAX_EXPERTS);
  assign emit_last = ({1'b0, s} == (k_sel - 4'd1));
  assign diff      = {sc_last[SCORE_W-1], sc_last} - {ru_score[SCORE_W-1], ru_score};

  // Insert during the probability handoff, rotate the row towards cell 0 while
  // sweeping and emitting, and empty it when a token is finished.
  always_comb begin
    ctrl.ins = (state == S_PROB) && prob_done && (count < MAX_EXPERTS);
    ctrl.rot = (state == S_SCAN) || ((state == S_EMIT) && out_free);
    ctrl.clr = ((state == S_ERR) && out_free)
            || ((state == S_EMIT) && out_free && emit_last);
  end

  erk_prob u_prob (
    .clk   (clk),
    .rst   (rst),
    .start (in_valid && in_ready),
    .logit (logit),
    .done  (prob_done),
    .prob  (prob)
  );

  erk_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIVS),
    .num   (prod),
    .den   (sum),
    .done  (div_done),
    .quo   (quo)
  );

  for (genvar g = 0; g < RANK_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      erk_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .new_entry (new_e),
        .up_in     (new_e),
        .down_in   (cells[1]),
        .take_in   (1'b0),
        .take_out  (take[0]),
        .q         (cells[0])
      );
    end else begin : g_rest
      erk_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .new_entry (new_e),
        .up_in     (cells[g-1]),
        .down_in   (cells[(g+1) % RANK_DEPTH]),
        .take_in   (take[g-1]),
        .take_out  (take[g]),
        .q         (cells[g])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      k_sel     <= K_W'(1);
      scale     <= SCALE_RESET;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_K_SELECT:     k_sel <= cfg_data[K_W-1:0];
          REG_WEIGHT_SCALE: scale <= cfg_data;
        endcase
      end
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            bias_q <= bias;
            last_q <= last_expert;
            state  <= S_PROB;
          end
        end
        S_PROB: begin
          if (prob_done) begin
            if (count <= MAX_EXPERTS) begin
              count <= count + 9'd1;
            end
            state <= last_q ? S_CHECK : S_IDLE;
          end
        end
        S_CHECK: begin
          sum      <= '0;
          j        <= '0;
          ru_valid <= 1'b0;
          ru_id    <= '0;
          state    <= tok_err ? S_ERR : S_SCAN;
        end
        S_ERR: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            slot_index      <= '0;
            expert_id       <= '0;
            route_weight    <= '0;
            runner_up_id    <= '0;
            runner_up_valid <= 1'b0;
            score_margin    <= '0;
            error_flag      <= 1'b1;
            last_result     <= 1'b1;
            count           <= '0;
            state           <= S_IDLE;
          end
        end
        S_SCAN: begin
          // Cell 0 shows slot j of the list in this cycle.
          if (j < k_sel) begin
            sum <= sum + {{(SUM_W-PROB_W){1'b0}}, head.prob};
          end
          if (j == k_sel - 4'd1) begin
            sc_last <= head.score;
          end
          if (j == k_sel) begin
            ru_valid <= head.valid;
            ru_id    <= head.valid ? head.id : '0;
            ru_score <= head.score;
          end
          j <= j + 4'd1;
          if (j == IDX_W'(RANK_DEPTH - 1)) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          if (sum < SUM_FLOOR) begin
            sum <= SUM_FLOOR;
          end
          if (!ru_valid) begin
            margin <= MARGIN_MAX;
          end else if (diff > $signed({2'b00, MARGIN_MAX})) begin
            margin <= MARGIN_MAX;
          end else if (diff < $signed({2'b11, MARGIN_MIN})) begin
            margin <= MARGIN_MIN;
          end else begin
            margin <= diff[31:0];
          end
          s     <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= head.prob * scale;
          state <= S_DIVS;
        end
        S_DIVS: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            slot_index      <= s;
            expert_id       <= head.id;
            route_weight    <= quo;
            runner_up_id    <= ru_id;
            runner_up_valid <= ru_valid;
            score_margin    <= margin;
            error_flag      <= 1'b0;
            last_result     <= emit_last;
            s               <= s + 3'd1;
            if (emit_last) begin
              count <= '0;
              state <= S_IDLE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_IMPLIES(a_error_item_clean, clk, rst, out_valid && error_flag, last_result && (route_weight == '0) && !runner_up_valid)
  `ASSERT_IMPLIES(a_slot_below_k, clk, rst, out_valid && !error_flag, {1'b0, slot_index} < k_sel)

endmodule
`default_nettype wire
